// ===== hdl/fdcp_pkg.sv =====
// Shared types and character codes for the framed decimal command parser.
// No dependencies; every other file refers to this package by scoped names.
package fdcp_pkg;

    // Frame and number characters (ASCII).
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_P    = 8'h50;
    localparam logic [7:0] CH_EQ   = 8'h3D;
    localparam logic [7:0] CH_BANG = 8'h21;
    localparam logic [7:0] CH_DOT  = 8'h2E;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    // Output field widths.
    localparam int ID_W   = 8;
    localparam int INT_W  = 24;
    localparam int FRAC_W = 14;

    // Frame parsing phases, one-hot.
    typedef enum logic [3:0] {
        PH_WAIT_HASH = 4'b0001,
        PH_WAIT_P    = 4'b0010,
        PH_ID        = 4'b0100,
        PH_NUM       = 4'b1000
    } phase_t;

    // One parsed command.
    typedef struct packed {
        logic [ID_W-1:0]   command_id;
        logic [INT_W-1:0]  integer_part;
        logic [FRAC_W-1:0] fraction_part;
        logic              overflowed;
        logic              bad_format;
    } result_t;

    // Ten to a small power; used only with constant arguments.
    function automatic int pow10(input int e);
        int r;
        r = 1;
        for (int k = 0; k < e; k++) begin
            r = r * 10;
        end
        return r;
    endfunction

endpackage

// ===== hdl/fdcp_parse_core.sv =====
// Frame state machine and number accumulators of the command parser.
// Consumes one registered byte per step; depends on fdcp_pkg.
module fdcp_parse_core #(
    parameter int INT_BITS    = 24,
    parameter int FRAC_DIGITS = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic [7:0]        rx_byte,
    output logic              emit,
    output fdcp_pkg::result_t result
);

    localparam int FACC_W   = $clog2(fdcp_pkg::pow10(FRAC_DIGITS));
    localparam int CNT_W    = $clog2(FRAC_DIGITS + 1);
    localparam int PROD_W   = INT_BITS + 4;
    localparam int IEXT_W   = (INT_BITS > fdcp_pkg::INT_W) ? INT_BITS : fdcp_pkg::INT_W;
    localparam int FEXT_W   = (FACC_W > fdcp_pkg::FRAC_W) ? FACC_W : fdcp_pkg::FRAC_W;

    fdcp_pkg::phase_t      phase_reg, phase_next;
    logic [7:0]            id_reg, id_next;
    logic [INT_BITS-1:0]   int_acc_reg, int_acc_next;
    logic [FACC_W-1:0]     frac_acc_reg, frac_acc_next;
    logic [CNT_W-1:0]      frac_cnt_reg, frac_cnt_next;
    logic                  dot_reg, dot_next;
    logic                  ovf_reg, ovf_next;
    logic                  err_reg, err_next;

    logic                  is_digit;
    logic [3:0]            digit;
    logic [PROD_W-1:0]     int_prod;
    logic [PROD_W-1:0]     int_limit;
    logic [FACC_W-1:0]     place;
    logic [FACC_W-1:0]     frac_add;
    logic [IEXT_W-1:0]     int_ext;
    logic [FEXT_W-1:0]     frac_ext;

    // Digit decode, the integer accumulator update and its saturation limit.
    assign is_digit  = (rx_byte >= fdcp_pkg::CH_ZERO) && (rx_byte <= fdcp_pkg::CH_NINE);
    assign digit     = 4'(rx_byte - fdcp_pkg::CH_ZERO);
    assign int_prod  = (PROD_W'(int_acc_reg) << 3) + (PROD_W'(int_acc_reg) << 1)
                     + PROD_W'(digit);
    assign int_limit = PROD_W'({INT_BITS{1'b1}});

    // Place value of the next fraction digit.
    always_comb begin
        place = '0;
        for (int i = 0; i < FRAC_DIGITS; i++) begin
            if (frac_cnt_reg == CNT_W'(i)) begin
                place = FACC_W'(fdcp_pkg::pow10(FRAC_DIGITS - 1 - i));
            end
        end
    end

    assign frac_add = FACC_W'(digit) * place;

    // A result leaves on the closing character of the number stage.
    assign emit = (phase_reg == fdcp_pkg::PH_NUM) && (rx_byte == fdcp_pkg::CH_BANG);

    assign int_ext  = IEXT_W'(int_acc_reg);
    assign frac_ext = FEXT_W'(frac_acc_reg);

    always_comb begin
        result.command_id    = id_reg;
        result.integer_part  = int_ext[fdcp_pkg::INT_W-1:0];
        result.fraction_part = frac_ext[fdcp_pkg::FRAC_W-1:0];
        result.overflowed    = ovf_reg;
        result.bad_format    = err_reg;
    end

    // Next state for one item.
    always_comb begin
        phase_next    = phase_reg;
        id_next       = id_reg;
        int_acc_next  = int_acc_reg;
        frac_acc_next = frac_acc_reg;
        frac_cnt_next = frac_cnt_reg;
        dot_next      = dot_reg;
        ovf_next      = ovf_reg;
        err_next      = err_reg;
        if (step) begin
            case (phase_reg)
                fdcp_pkg::PH_WAIT_HASH: begin
                    if (rx_byte == fdcp_pkg::CH_HASH) begin
                        int_acc_next  = '0;
                        frac_acc_next = '0;
                        frac_cnt_next = '0;
                        dot_next      = 1'b0;
                        ovf_next      = 1'b0;
                        err_next      = 1'b0;
                        phase_next    = fdcp_pkg::PH_WAIT_P;
                    end
                end
                fdcp_pkg::PH_WAIT_P: begin
                    if (rx_byte == fdcp_pkg::CH_P) begin
                        phase_next = fdcp_pkg::PH_ID;
                    end
                end
                fdcp_pkg::PH_ID: begin
                    if (rx_byte == fdcp_pkg::CH_EQ) begin
                        phase_next = fdcp_pkg::PH_NUM;
                    end else begin
                        id_next = rx_byte - fdcp_pkg::CH_ZERO;
                    end
                end
                fdcp_pkg::PH_NUM: begin
                    if (emit) begin
                        phase_next = fdcp_pkg::PH_WAIT_HASH;
                    end else if (rx_byte == fdcp_pkg::CH_DOT) begin
                        if (dot_reg) begin
                            err_next = 1'b1;
                        end else begin
                            dot_next = 1'b1;
                        end
                    end else if (is_digit) begin
                        if (!dot_reg) begin
                            if (int_prod > int_limit) begin
                                int_acc_next = {INT_BITS{1'b1}};
                                ovf_next     = 1'b1;
                            end else begin
                                int_acc_next = int_prod[INT_BITS-1:0];
                            end
                        end else if (frac_cnt_reg < CNT_W'(FRAC_DIGITS)) begin
                            frac_acc_next = frac_acc_reg + frac_add;
                            frac_cnt_next = frac_cnt_reg + CNT_W'(1);
                        end
                    end else begin
                        err_next = 1'b1;
                    end
                end
                default: begin
                    phase_next = fdcp_pkg::PH_WAIT_HASH;
                end
            endcase
        end
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= fdcp_pkg::PH_WAIT_HASH;
            id_reg       <= '0;
            int_acc_reg  <= '0;
            frac_acc_reg <= '0;
            frac_cnt_reg <= '0;
            dot_reg      <= 1'b0;
            ovf_reg      <= 1'b0;
            err_reg      <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            id_reg       <= id_next;
            int_acc_reg  <= int_acc_next;
            frac_acc_reg <= frac_acc_next;
            frac_cnt_reg <= frac_cnt_next;
            dot_reg      <= dot_next;
            ovf_reg      <= ovf_next;
            err_reg      <= err_next;
        end
    end

    // A saturated integer sits exactly at its maximum.
    a_ovf_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> (int_acc_reg == {INT_BITS{1'b1}}))
        else $error("overflow flag set without a saturated integer");

    // The fraction digit count never passes the kept digits.
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        frac_cnt_reg <= CNT_W'(FRAC_DIGITS))
        else $error("fraction digit count out of range");

    // The fraction stays below one whole unit.
    a_frac_range: assert property (@(posedge aclk) disable iff (!aresetn)
        frac_acc_reg < FACC_W'(fdcp_pkg::pow10(FRAC_DIGITS)))
        else $error("fraction accumulator out of range");

    // Fraction digits only follow a dot.
    a_frac_dot: assert property (@(posedge aclk) disable iff (!aresetn)
        (frac_cnt_reg != '0) |-> dot_reg)
        else $error("fraction digits counted without a dot");

endmodule

// ===== hdl/fdcp_out_reg.sv =====
// Result register of the command parser: holds one item until it is taken.
// Depends on fdcp_pkg for the result type.
module fdcp_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  fdcp_pkg::result_t load_data,
    output logic              out_free,
    input  logic              m_ready,
    output logic              m_valid,
    output fdcp_pkg::result_t m_data
);

    logic              vld_reg, vld_next;
    fdcp_pkg::result_t data_reg, data_next;

    // The register takes a new item when empty or when its item leaves.
    assign out_free = !vld_reg || m_ready;

    always_comb begin
        vld_next  = vld_reg;
        data_next = data_reg;
        if (load) begin
            vld_next  = 1'b1;
            data_next = load_data;
        end else if (m_ready) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign m_valid = vld_reg;
    assign m_data  = data_reg;

    // A load only happens when there is room for it.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> out_free)
        else $error("result register overwritten while full");

    // A loaded item is presented in the next cycle.
    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> m_valid)
        else $error("loaded item not presented");

    // An item that was not taken is still presented.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("pending item dropped");

endmodule

// ===== hdl/framed_decimal_command_parser_unit.sv =====
// An accepted byte is held in the input register; a held '!' loads its result
// into the result register (m_valid) once that has room. Throughput: one byte
// per cycle unless a '!' waits for room; the frame state updates once per byte.
// Reset: aresetn is synchronous, active low; it clears the frame state, the held
// id, the accumulators and flags, and both valid flags.
// Depends on fdcp_pkg, fdcp_parse_core and fdcp_out_reg.
module framed_decimal_command_parser_unit #(
    parameter int INT_BITS    = 24,
    parameter int FRAC_DIGITS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_command_id,
    output logic [23:0] m_integer_part,
    output logic [13:0] m_fraction_part,
    output logic        m_overflowed,
    output logic        m_bad_format
);

    logic              in_vld_reg, in_vld_next;
    logic [7:0]        in_byte_reg, in_byte_next;
    logic              emit;
    logic              fire;
    logic              out_free;
    logic              s_take;
    fdcp_pkg::result_t core_result;
    fdcp_pkg::result_t m_data;

    // The held item is processed unless its result has nowhere to go.
    assign fire    = in_vld_reg && (!emit || out_free);
    assign s_ready = !in_vld_reg || fire;
    assign s_take  = s_valid && s_ready;

    // Input register.
    always_comb begin
        in_vld_next  = in_vld_reg;
        in_byte_next = in_byte_reg;
        if (s_take) begin
            in_vld_next  = 1'b1;
            in_byte_next = s_rx_byte;
        end else if (fire) begin
            in_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_byte_reg <= in_byte_next;
    end

    // Frame parser.
    fdcp_parse_core #(
        .INT_BITS    (INT_BITS),
        .FRAC_DIGITS (FRAC_DIGITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (fire),
        .rx_byte (in_byte_reg),
        .emit    (emit),
        .result  (core_result)
    );

    // Result register.
    fdcp_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (fire && emit),
        .load_data (core_result),
        .out_free  (out_free),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data)
    );

    assign m_command_id    = m_data.command_id;
    assign m_integer_part  = m_data.integer_part;
    assign m_fraction_part = m_data.fraction_part;
    assign m_overflowed    = m_data.overflowed;
    assign m_bad_format    = m_data.bad_format;

    // The input side only stalls behind a held item.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_vld_reg && emit && !out_free))
        else $error("input stalled without a blocked item");

    // An accepted byte is held in the input register next cycle.
    a_take_held: assert property (@(posedge aclk) disable iff (!aresetn)
        s_take |=> in_vld_reg)
        else $error("accepted item lost");

    // A processed byte that is not replaced leaves the input register.
    a_fire_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && !s_take) |=> !in_vld_reg)
        else $error("processed item repeated");

endmodule
